// ----- rtl/core/ppd_pkg.sv -----
// Package for the periodic pair displacement block: widths, pipeline depths,
// stage record types and the arctangent table. Depends on nothing.
package ppd_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int LENGTH_EPSILON = (1 << FRACTION_BITS) / 1000000;

   localparam int COORD_W = 31;
   localparam int DELTA_W = 32;
   localparam int MAG_W = 31;
   localparam int SQUARE_W = 2 * MAG_W;
   localparam int SUM_W = 64;
   localparam int ROOT_W = 32;
   localparam int REM_W = ROOT_W + 2;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int UNIT_W = 16;
   localparam int QUOT_STAGES = UNIT_W;
   localparam int CORD_W = 36;
   localparam int ACC_W = 32;
   localparam int ANGLE_W = 16;
   localparam int ATAN_TABLE_SIZE = 24;
   localparam int LATENCY = SQRT_STAGES + QUOT_STAGES + 6;

   localparam logic [COORD_W-1:0] BOX_RESET = 31'd16777216;
   localparam logic signed [ACC_W-1:0] QUARTER_TURN_Q28 = 32'sd421657428;
   localparam logic signed [ANGLE_W:0] ANGLE_MAX_Q13 = 17'sd25736;
   localparam logic [UNIT_W-1:0] UNIT_POS_MAX = 16'd32767;

   localparam logic signed [ACC_W-1:0] ATAN_Q28 [ATAN_TABLE_SIZE] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
      32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
      32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
      32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
      32'sd256, 32'sd128, 32'sd64, 32'sd32
   };

   function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
      logic signed [ACC_W-1:0] value;
      value = '0;
      if (i < ATAN_TABLE_SIZE) begin
         value = ATAN_Q28[i];
      end
      return value;
   endfunction

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } delta_stage_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [MAG_W-1:0]          ax;
      logic [MAG_W-1:0]          ay;
      logic [SQUARE_W-1:0]       sqx;
      logic [SQUARE_W-1:0]       sqy;
      logic signed [CORD_W-1:0]  cx;
      logic signed [CORD_W-1:0]  cy;
      logic signed [ACC_W-1:0]   cz;
   } square_stage_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [MAG_W-1:0]          ax;
      logic [MAG_W-1:0]          ay;
      logic [SUM_W-1:0]          v;
      logic [REM_W-1:0]          rem;
      logic [ROOT_W-1:0]         root;
      logic signed [CORD_W-1:0]  cx;
      logic signed [CORD_W-1:0]  cy;
      logic signed [ACC_W-1:0]   cz;
   } sqrt_stage_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic                      ax_lsb;
      logic                      ay_lsb;
      logic [ROOT_W-1:0]         root;
      logic [ROOT_W-1:0]         rem_c;
      logic [ROOT_W-1:0]         rem_s;
      logic [UNIT_W-1:0]         q_c;
      logic [UNIT_W-1:0]         q_s;
      logic signed [ACC_W-1:0]   cz;
   } quot_stage_type;

endpackage

// ----- rtl/core/periodic_pair_displacement.sv -----
// Top level of the periodic pair displacement block: minimum-image wrap,
// length, direction cosine and sine, and direction angle. Uses ppd_pkg.

// One request enters in every cycle; busy is never raised and each request
// yields one result, in order. The pipeline holds the bit-per-stage square root
// (32 stages) followed by the bit-per-stage unit vector division (16 stages); the
// angle CORDIC runs beside the square root. Results are shown for one cycle under
// rsp_valid and cannot be held off. The user must write the box size only while
// no request is in flight; the block itself does not enforce it.
module periodic_pair_displacement (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ppd_pkg::COORD_W-1:0] req_first_x,
   input  logic [ppd_pkg::COORD_W-1:0] req_first_y,
   input  logic [ppd_pkg::COORD_W-1:0] req_second_x,
   input  logic [ppd_pkg::COORD_W-1:0] req_second_y,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ppd_pkg::COORD_W-1:0] csr_box_size,
   output logic                        rsp_valid,
   output logic signed [ppd_pkg::DELTA_W-1:0] rsp_delta_x,
   output logic signed [ppd_pkg::DELTA_W-1:0] rsp_delta_y,
   output logic [ppd_pkg::MAG_W-1:0]   rsp_length,
   output logic signed [ppd_pkg::UNIT_W-1:0] rsp_dir_cos,
   output logic signed [ppd_pkg::UNIT_W-1:0] rsp_dir_sin,
   output logic signed [ppd_pkg::ANGLE_W-1:0] rsp_angle,
   output logic                        rsp_zero_length
);
   import ppd_pkg::*;

   logic [COORD_W-1:0] box_ff;

   delta_stage_type  raw_ff, raw_in;
   delta_stage_type  wrap_ff, wrap_in;
   square_stage_type square_ff, square_in;
   sqrt_stage_type   sq_ff [SQRT_STAGES+1];
   sqrt_stage_type   sum_in;
   quot_stage_type   qt_ff [QUOT_STAGES+1];
   quot_stage_type   quot_init_in;

   logic raw_vld_ff, wrap_vld_ff, square_vld_ff;
   logic [SQRT_STAGES:0] sq_vld_ff;
   logic [QUOT_STAGES:0] qt_vld_ff;

   logic signed [DELTA_W-1:0] rsp_delta_x_in, rsp_delta_y_in;
   logic [MAG_W-1:0]          rsp_length_in;
   logic signed [UNIT_W-1:0]  rsp_dir_cos_in, rsp_dir_sin_in;
   logic signed [ANGLE_W-1:0] rsp_angle_in;
   logic                      rsp_zero_length_in;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= BOX_RESET;
      end else if (csr_valid && csr_ready) begin
         box_ff <= csr_box_size;
      end
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_vld_ff    <= 1'b0;
         wrap_vld_ff   <= 1'b0;
         square_vld_ff <= 1'b0;
         sq_vld_ff     <= '0;
         qt_vld_ff     <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         raw_vld_ff    <= start && !busy;
         wrap_vld_ff   <= raw_vld_ff;
         square_vld_ff <= wrap_vld_ff;
         sq_vld_ff     <= {sq_vld_ff[SQRT_STAGES-1:0], square_vld_ff};
         qt_vld_ff     <= {qt_vld_ff[QUOT_STAGES-1:0], sq_vld_ff[SQRT_STAGES]};
         rsp_valid     <= qt_vld_ff[QUOT_STAGES];
      end
   end

   always_comb begin
      raw_in.dx = $signed({1'b0, req_second_x}) - $signed({1'b0, req_first_x});
      raw_in.dy = $signed({1'b0, req_second_y}) - $signed({1'b0, req_first_y});
   end

   function automatic logic signed [DELTA_W-1:0] wrap_delta(
      input logic signed [DELTA_W-1:0] d,
      input logic [COORD_W-1:0]        box
   );
      logic [DELTA_W-1:0]        mag;
      logic signed [DELTA_W-1:0] result;
      mag = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
      result = d;
      if (d != 0 && {mag[MAG_W-1:0], 1'b0} >= {1'b0, box}) begin
         if (d[DELTA_W-1]) begin
            result = d + $signed({1'b0, box});
         end else begin
            result = d - $signed({1'b0, box});
         end
      end
      return result;
   endfunction

   always_comb begin
      wrap_in.dx = wrap_delta(raw_ff.dx, box_ff);
      wrap_in.dy = wrap_delta(raw_ff.dy, box_ff);
   end

   always_comb begin
      logic signed [CORD_W-1:0] ex, ey;
      ex = CORD_W'(wrap_ff.dx);
      ey = CORD_W'(wrap_ff.dy);
      square_in.dx  = wrap_ff.dx;
      square_in.dy  = wrap_ff.dy;
      square_in.ax  = wrap_ff.dx[DELTA_W-1] ? MAG_W'(-wrap_ff.dx) : MAG_W'(wrap_ff.dx);
      square_in.ay  = wrap_ff.dy[DELTA_W-1] ? MAG_W'(-wrap_ff.dy) : MAG_W'(wrap_ff.dy);
      square_in.sqx = square_in.ax * square_in.ax;
      square_in.sqy = square_in.ay * square_in.ay;
      square_in.cx  = ex;
      square_in.cy  = ey;
      square_in.cz  = '0;
      if (ex < 0) begin
         if (ey >= 0) begin
            square_in.cx = ey;
            square_in.cy = -ex;
            square_in.cz = QUARTER_TURN_Q28;
         end else begin
            square_in.cx = -ey;
            square_in.cy = ex;
            square_in.cz = -QUARTER_TURN_Q28;
         end
      end
   end

   always_comb begin
      sum_in.dx   = square_ff.dx;
      sum_in.dy   = square_ff.dy;
      sum_in.ax   = square_ff.ax;
      sum_in.ay   = square_ff.ay;
      sum_in.v    = SUM_W'(square_ff.sqx) + SUM_W'(square_ff.sqy);
      sum_in.rem  = '0;
      sum_in.root = '0;
      sum_in.cx   = square_ff.cx;
      sum_in.cy   = square_ff.cy;
      sum_in.cz   = square_ff.cz;
   end

   always_ff @(posedge clock) begin
      raw_ff    <= raw_in;
      wrap_ff   <= wrap_in;
      square_ff <= square_in;
      sq_ff[0]  <= sum_in;
   end

   // Square root one result bit per stage; the CORDIC steps ride along.
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      sqrt_stage_type   stage_in;
      logic [REM_W+1:0] trial_rem;
      logic [REM_W+1:0] trial;
      always_comb begin
         stage_in  = sq_ff[k];
         trial_rem = {sq_ff[k].rem, sq_ff[k].v[SUM_W-1-2*k -: 2]};
         trial     = {2'b00, sq_ff[k].root, 2'b01};
         if (trial_rem >= trial) begin
            stage_in.rem  = REM_W'(trial_rem - trial);
            stage_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            stage_in.rem  = REM_W'(trial_rem);
            stage_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
         if (k < CORDIC_STAGES) begin
            if (sq_ff[k].cy >= 0) begin
               stage_in.cx = sq_ff[k].cx + (sq_ff[k].cy >>> k);
               stage_in.cy = sq_ff[k].cy - (sq_ff[k].cx >>> k);
               stage_in.cz = sq_ff[k].cz + atan_entry(k);
            end else begin
               stage_in.cx = sq_ff[k].cx - (sq_ff[k].cy >>> k);
               stage_in.cy = sq_ff[k].cy + (sq_ff[k].cx >>> k);
               stage_in.cz = sq_ff[k].cz - atan_entry(k);
            end
         end
      end
      always_ff @(posedge clock) begin
         sq_ff[k+1] <= stage_in;
      end
   end

   always_comb begin
      quot_init_in.dx     = sq_ff[SQRT_STAGES].dx;
      quot_init_in.dy     = sq_ff[SQRT_STAGES].dy;
      quot_init_in.ax_lsb = sq_ff[SQRT_STAGES].ax[0];
      quot_init_in.ay_lsb = sq_ff[SQRT_STAGES].ay[0];
      quot_init_in.root   = sq_ff[SQRT_STAGES].root;
      quot_init_in.rem_c  = ROOT_W'(sq_ff[SQRT_STAGES].ax[MAG_W-1:1]);
      quot_init_in.rem_s  = ROOT_W'(sq_ff[SQRT_STAGES].ay[MAG_W-1:1]);
      quot_init_in.q_c    = '0;
      quot_init_in.q_s    = '0;
      quot_init_in.cz     = sq_ff[SQRT_STAGES].cz;
   end

   always_ff @(posedge clock) begin
      qt_ff[0] <= quot_init_in;
   end

   // Restoring division of magnitude times 2^15 by the root, one bit per stage.
   for (genvar j = 0; j < QUOT_STAGES; j++) begin : g_quot
      quot_stage_type  stage_in;
      logic [ROOT_W:0] trial_c;
      logic [ROOT_W:0] trial_s;
      always_comb begin
         stage_in = qt_ff[j];
         trial_c  = {qt_ff[j].rem_c, (j == 0) ? qt_ff[j].ax_lsb : 1'b0};
         trial_s  = {qt_ff[j].rem_s, (j == 0) ? qt_ff[j].ay_lsb : 1'b0};
         if (trial_c >= {1'b0, qt_ff[j].root}) begin
            stage_in.rem_c = ROOT_W'(trial_c - {1'b0, qt_ff[j].root});
            stage_in.q_c   = {qt_ff[j].q_c[UNIT_W-2:0], 1'b1};
         end else begin
            stage_in.rem_c = ROOT_W'(trial_c);
            stage_in.q_c   = {qt_ff[j].q_c[UNIT_W-2:0], 1'b0};
         end
         if (trial_s >= {1'b0, qt_ff[j].root}) begin
            stage_in.rem_s = ROOT_W'(trial_s - {1'b0, qt_ff[j].root});
            stage_in.q_s   = {qt_ff[j].q_s[UNIT_W-2:0], 1'b1};
         end else begin
            stage_in.rem_s = ROOT_W'(trial_s);
            stage_in.q_s   = {qt_ff[j].q_s[UNIT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         qt_ff[j+1] <= stage_in;
      end
   end

   always_comb begin
      quot_stage_type          last;
      logic signed [ACC_W:0]   rounded;
      logic signed [ANGLE_W:0] angle_wide;
      last = qt_ff[QUOT_STAGES];
      rsp_delta_x_in = last.dx;
      rsp_delta_y_in = last.dy;
      rsp_length_in  = last.root[ROOT_W-1] ? {MAG_W{1'b1}} : last.root[MAG_W-1:0];
      rsp_zero_length_in = rsp_length_in <= MAG_W'(LENGTH_EPSILON);
      if (last.dx[DELTA_W-1]) begin
         rsp_dir_cos_in = $signed(UNIT_W'(0 - last.q_c));
      end else begin
         rsp_dir_cos_in = $signed((last.q_c > UNIT_POS_MAX) ? UNIT_POS_MAX : last.q_c);
      end
      if (last.dy[DELTA_W-1]) begin
         rsp_dir_sin_in = $signed(UNIT_W'(0 - last.q_s));
      end else begin
         rsp_dir_sin_in = $signed((last.q_s > UNIT_POS_MAX) ? UNIT_POS_MAX : last.q_s);
      end
      rounded    = ((ACC_W+1)'(last.cz) + (ACC_W+1)'(1 << 14)) >>> 15;
      angle_wide = rounded[ANGLE_W:0];
      if (angle_wide > ANGLE_MAX_Q13 || angle_wide <= -ANGLE_MAX_Q13) begin
         angle_wide = ANGLE_MAX_Q13;
      end
      rsp_angle_in = angle_wide[ANGLE_W-1:0];
      if (rsp_zero_length_in) begin
         rsp_dir_cos_in = '0;
         rsp_dir_sin_in = '0;
         rsp_angle_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_delta_x     <= rsp_delta_x_in;
      rsp_delta_y     <= rsp_delta_y_in;
      rsp_length      <= rsp_length_in;
      rsp_dir_cos     <= rsp_dir_cos_in;
      rsp_dir_sin     <= rsp_dir_sin_in;
      rsp_angle       <= rsp_angle_in;
      rsp_zero_length <= rsp_zero_length_in;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("A request did not produce its result at the expected cycle.");

   a_zero_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
         rsp_dir_cos == 0 && rsp_dir_sin == 0 && rsp_angle == 0)
      else $error("A zero-length result carries a nonzero direction.");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle <= 16'sd25736 && rsp_angle > -16'sd25736)
      else $error("The angle is outside the half-open range.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result appeared right after reset.");

endmodule
